FILE: hdl/avs_pkg.sv
`timescale 1ns / 1ps

package avs_pkg;

  localparam int MAX_LEVELS_DEF = 256;
  localparam int FRAC_BITS = 16;

  localparam logic [1:0] CFG_RADIAL_CELLS = 2'd0;
  localparam logic [1:0] CFG_VERTICAL_CELLS = 2'd1;
  localparam logic [1:0] CFG_INV_TWO_RADIAL_STEP = 2'd2;
  localparam logic [1:0] CFG_INV_TWO_VERTICAL_STEP = 2'd3;

  localparam logic [15:0] RADIAL_CELLS_RST = 16'd64;
  localparam logic [8:0] VERTICAL_CELLS_RST = 9'd64;
  localparam logic [31:0] INV_STEP_RST = 32'd65536;

  localparam logic [2:0] RD_LAST = 3'd6;

  localparam logic signed [63:0] DWZ_LIM = 64'sd1 <<< (32 + FRAC_BITS);
  localparam logic [95:0] HALF_F = 96'd1 << (FRAC_BITS - 1);
  localparam logic [95:0] HALF_F1 = 96'd1 << FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIFF,
    ST_MLOAD,
    ST_MLO,
    ST_MHI,
    ST_MRND,
    ST_MSTORE,
    ST_VZ,
    ST_DONE
  } avs_state_t;

  typedef enum logic [2:0] {
    OP_DV,
    OP_VC,
    OP_DU,
    OP_DWR,
    OP_DWZ,
    OP_ST
  } avs_op_t;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic [2:0] rd_step;
    logic       diff;
    logic       mload;
    logic       mlo;
    logic       mhi;
    logic       mrnd;
    logic       mstore;
    logic       vz;
    logic       out_load;
    avs_op_t    op;
  } avs_cmd_t;

  typedef struct packed {
    logic interior;
    logic out_free;
  } avs_status_t;

  function automatic avs_op_t op_next(input avs_op_t op);
    avs_op_t r;
    case (op)
      OP_DV:   r = OP_VC;
      OP_VC:   r = OP_DU;
      OP_DU:   r = OP_DWR;
      OP_DWR:  r = OP_DWZ;
      OP_DWZ:  r = OP_ST;
      default: r = OP_DV;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/avs_ram.sv
`timescale 1ns / 1ps

module avs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/avs_ctrl.sv
`timescale 1ns / 1ps

module avs_ctrl
  import avs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  avs_status_t status,
  output avs_cmd_t    cmd
);

  avs_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  avs_op_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= 3'd0;
      op_r <= OP_DV;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      op_r <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    op_nxt = op_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = 3'd0;
        if (in_valid && status.interior) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == RD_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DIFF;
      ST_DIFF: begin
        op_nxt = OP_DV;
        state_nxt = ST_MLOAD;
      end
      ST_MLOAD: state_nxt = ST_MLO;
      ST_MLO: state_nxt = ST_MHI;
      ST_MHI: state_nxt = ST_MRND;
      ST_MRND: state_nxt = ST_MSTORE;
      ST_MSTORE: begin
        if (op_r == OP_VC) begin
          state_nxt = ST_VZ;
        end else if (op_r == OP_ST) begin
          state_nxt = ST_DONE;
        end else begin
          op_nxt = op_next(op_r);
          state_nxt = ST_MLOAD;
        end
      end
      ST_VZ: begin
        op_nxt = OP_DU;
        state_nxt = ST_MLOAD;
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.op = op_r;
    cmd.rd_step = cnt_r;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.accept = in_valid;
      end
      ST_READ: cmd.rd_en = 1'b1;
      ST_DIFF: cmd.diff = 1'b1;
      ST_MLOAD: cmd.mload = 1'b1;
      ST_MLO: cmd.mlo = 1'b1;
      ST_MHI: cmd.mhi = 1'b1;
      ST_MRND: cmd.mrnd = 1'b1;
      ST_MSTORE: cmd.mstore = 1'b1;
      ST_VZ: cmd.vz = 1'b1;
      ST_DONE: cmd.out_load = 1'b1;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_read_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && cnt_r == RD_LAST) |=> (state_r == ST_DRAIN))
    else $error("read sequence did not end in drain");

  a_last_op_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MSTORE && op_r == OP_ST) |=> (state_r == ST_DONE))
    else $error("last product did not lead to result");
`endif

endmodule

FILE: hdl/avs_datapath.sv
`timescale 1ns / 1ps

module avs_datapath
  import avs_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] in_radial_velocity,
  input  logic signed [31:0] in_azimuthal_velocity,
  input  logic signed [31:0] in_vertical_velocity,
  input  logic [31:0]        in_inverse_radius,
  input  logic               in_plane_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_radial_index,
  output logic [7:0]         out_vertical_index,
  output logic signed [31:0] out_vorticity_azimuthal,
  output logic signed [31:0] out_vorticity_vertical,
  output logic signed [31:0] out_stretching,
  input  avs_cmd_t           cmd,
  output avs_status_t        status
);

  localparam int LW = $clog2(MAX_LEVELS);
  localparam int NZW = (LW + 1 > 9) ? LW + 1 : 9;
  localparam int DEPTH = 3 * MAX_LEVELS;
  localparam int AW = $clog2(DEPTH);

  function automatic logic [AW-1:0] ram_addr(input logic [1:0] slot, input logic [LW-1:0] lvl);
    logic [AW-1:0] base;
    case (slot)
      2'd0:    base = '0;
      2'd1:    base = AW'(MAX_LEVELS);
      default: base = AW'(2 * MAX_LEVELS);
    endcase
    return base + AW'(lvl);
  endfunction

  function automatic logic signed [34:0] sx35(input logic [31:0] x);
    return {{3{x[31]}}, x};
  endfunction

  logic [15:0] radial_cells_r;
  logic [8:0]  vertical_cells_r;
  logic [31:0] irs_r, ivs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radial_cells_r <= RADIAL_CELLS_RST;
      vertical_cells_r <= VERTICAL_CELLS_RST;
      irs_r <= INV_STEP_RST;
      ivs_r <= INV_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIAL_CELLS: radial_cells_r <= cfg_data[15:0];
        CFG_VERTICAL_CELLS: vertical_cells_r <= cfg_data[8:0];
        CFG_INV_TWO_RADIAL_STEP: irs_r <= cfg_data;
        CFG_INV_TWO_VERTICAL_STEP: ivs_r <= cfg_data;
        default: irs_r <= irs_r;
      endcase
    end
  end

  logic [16:0]    nr;
  logic [NZW-1:0] nz;

  always_comb begin
    nr = (radial_cells_r < 16'd3) ? 17'd3 : {1'b0, radial_cells_r};
    nz = NZW'(vertical_cells_r);
    if (nz < NZW'(3)) begin
      nz = NZW'(3);
    end
    if (nz > NZW'(MAX_LEVELS)) begin
      nz = NZW'(MAX_LEVELS);
    end
  end

  logic [15:0]   row_r;
  logic [LW-1:0] lvl_r;
  logic [1:0]    slot_r;

  logic [16:0]    row1, row2, row3;
  logic [NZW-1:0] lvl0, lvl2, lvl3;
  logic [1:0]     slot1, slot2, slot3;

  always_comb begin
    row1 = in_plane_start ? 17'd0 : {1'b0, row_r};
    lvl0 = in_plane_start ? '0 : NZW'(lvl_r);
    slot1 = in_plane_start ? 2'd0 : slot_r;
    lvl2 = lvl0;
    if (lvl0 >= nz) begin
      lvl2 = '0;
      row1 = row1 + 17'd1;
      slot1 = slot_inc(slot1);
    end
    row2 = row1;
    slot2 = slot1;
    if (row1 >= nr) begin
      row2 = 17'd0;
      slot2 = 2'd0;
    end
    lvl3 = lvl2 + NZW'(1);
    row3 = row2;
    slot3 = slot2;
    if (lvl3 >= nz) begin
      lvl3 = '0;
      row3 = row2 + 17'd1;
      slot3 = slot_inc(slot2);
      if (row3 >= nr) begin
        row3 = 17'd0;
        slot3 = 2'd0;
      end
    end
  end

  assign status.interior = (row2 >= 17'd2) && (lvl2 >= NZW'(1)) && (lvl2 + NZW'(2) <= nz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      lvl_r <= '0;
      slot_r <= 2'd0;
    end else if (cmd.accept) begin
      row_r <= row3[15:0];
      lvl_r <= lvl3[LW-1:0];
      slot_r <= slot3;
    end
  end

  logic [31:0] invr_r [3];
  logic [1:0]  slot_x_r, slot_c_r, slot_p_r;
  logic [LW-1:0] k_r;
  logic [15:0] row_out_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      invr_r[slot2] <= in_inverse_radius;
      slot_x_r <= slot2;
      slot_c_r <= slot_dec(slot2);
      slot_p_r <= slot_inc(slot2);
      k_r <= lvl2[LW-1:0];
      row_out_r <= row2[15:0] - 16'd1;
    end
  end

  logic [AW-1:0] waddr, u_raddr, v_raddr, w_raddr;
  logic [31:0]   u_rd, v_rd, w_rd;
  logic [LW-1:0] k_up, k_dn, k_dn2;

  assign waddr = ram_addr(slot2, lvl2[LW-1:0]);
  assign k_up = k_r + LW'(1);
  assign k_dn = k_r - LW'(1);
  assign k_dn2 = (k_r > LW'(1)) ? k_r - LW'(2) : '0;

  always_comb begin
    u_raddr = ram_addr(slot_c_r, k_up);
    v_raddr = ram_addr(slot_c_r, k_r);
    w_raddr = ram_addr(slot_c_r, k_dn2);
    case (cmd.rd_step)
      3'd0: begin
        w_raddr = ram_addr(slot_x_r, k_dn);
        v_raddr = ram_addr(slot_p_r, k_r);
      end
      3'd1: begin
        u_raddr = ram_addr(slot_p_r, k_up);
        w_raddr = ram_addr(slot_p_r, k_r);
      end
      3'd2: begin
        u_raddr = ram_addr(slot_c_r, k_dn);
        w_raddr = ram_addr(slot_p_r, k_dn);
      end
      3'd3: begin
        u_raddr = ram_addr(slot_p_r, k_dn);
        w_raddr = ram_addr(slot_c_r, k_up);
      end
      3'd4: w_raddr = ram_addr(slot_c_r, k_r);
      3'd5: w_raddr = ram_addr(slot_c_r, k_dn);
      default: w_raddr = ram_addr(slot_c_r, k_dn2);
    endcase
  end

  avs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_u (
    .clk(clk), .we(cmd.accept), .waddr(waddr), .wdata(in_radial_velocity),
    .raddr(u_raddr), .rdata(u_rd)
  );

  avs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_v (
    .clk(clk), .we(cmd.accept), .waddr(waddr), .wdata(in_azimuthal_velocity),
    .raddr(v_raddr), .rdata(v_rd)
  );

  avs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_w (
    .clk(clk), .we(cmd.accept), .waddr(waddr), .wdata(in_vertical_velocity),
    .raddr(w_raddr), .rdata(w_rd)
  );

  logic       vld_q_r;
  logic [2:0] step_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r <= 1'b0;
    end else begin
      vld_q_r <= cmd.rd_en;
    end
    step_q_r <= cmd.rd_step;
  end

  logic signed [34:0] du_r, dwr_r, dv_r, wa_r, wb_r, dz_r;
  logic signed [31:0] vc_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      du_r <= '0;
      dwr_r <= sx35(in_vertical_velocity);
      dv_r <= sx35(in_azimuthal_velocity);
      wa_r <= '0;
      wb_r <= '0;
    end else if (vld_q_r) begin
      case (step_q_r)
        3'd0: begin
          du_r <= du_r + sx35(u_rd);
          dwr_r <= dwr_r + sx35(w_rd);
          dv_r <= dv_r - sx35(v_rd);
        end
        3'd1: begin
          du_r <= du_r + sx35(u_rd);
          dwr_r <= dwr_r - sx35(w_rd);
          vc_r <= v_rd;
        end
        3'd2: begin
          du_r <= du_r - sx35(u_rd);
          dwr_r <= dwr_r - sx35(w_rd);
        end
        3'd3: begin
          du_r <= du_r - sx35(u_rd);
          wa_r <= wa_r + sx35(w_rd);
        end
        3'd4: wa_r <= wa_r + sx35(w_rd);
        3'd5: wb_r <= wb_r + sx35(w_rd);
        default: begin
          if (k_r > LW'(1)) begin
            wb_r <= wb_r + sx35(w_rd);
          end
        end
      endcase
    end else if (cmd.diff) begin
      dz_r <= wa_r - wb_r;
    end
  end

  logic [63:0] a_mag_r;
  logic [31:0] b_mag_r;
  logic        neg_r, sh_one_r;
  logic [63:0] pl_r, ph_r;
  logic [61:0] rmag_r;
  logic signed [63:0] m_dv_r, m_vc_r, m_du_r, m_dwr_r, m_st_r, dwz_r, mres;
  logic signed [31:0] vz_r;
  logic [32:0] b_abs;
  logic [95:0] rsum, rshift;

  logic signed [63:0] a_sel;
  logic signed [32:0] b_sel;
  logic               sh_sel;

  always_comb begin
    a_sel = 64'(dv_r);
    b_sel = {1'b0, irs_r};
    sh_sel = 1'b0;
    case (cmd.op)
      OP_DV: begin
        a_sel = 64'(dv_r);
        b_sel = {1'b0, irs_r};
      end
      OP_VC: begin
        a_sel = 64'(vc_r);
        b_sel = {1'b0, invr_r[slot_c_r]};
      end
      OP_DU: begin
        a_sel = 64'(du_r);
        b_sel = {1'b0, ivs_r};
        sh_sel = 1'b1;
      end
      OP_DWR: begin
        a_sel = 64'(dwr_r);
        b_sel = {1'b0, irs_r};
        sh_sel = 1'b1;
      end
      OP_DWZ: begin
        a_sel = 64'(dz_r);
        b_sel = {1'b0, ivs_r};
        sh_sel = 1'b1;
      end
      default: begin
        a_sel = dwz_r;
        b_sel = {vz_r[31], vz_r};
      end
    endcase
  end

  assign b_abs = b_sel[32] ? 33'(-b_sel) : 33'(b_sel);
  assign rsum = {ph_r, 32'd0} + {32'd0, pl_r} + (sh_one_r ? HALF_F1 : HALF_F);
  assign rshift = sh_one_r ? (rsum >> (FRAC_BITS + 1)) : (rsum >> FRAC_BITS);
  assign mres = neg_r ? -64'(rmag_r) : 64'(rmag_r);

  always_ff @(posedge clk) begin
    if (cmd.mload) begin
      a_mag_r <= a_sel[63] ? 64'(-a_sel) : 64'(a_sel);
      b_mag_r <= b_abs[31:0];
      neg_r <= a_sel[63] ^ b_sel[32];
      sh_one_r <= sh_sel;
    end
    if (cmd.mlo) begin
      pl_r <= 64'(a_mag_r[31:0]) * 64'(b_mag_r);
    end
    if (cmd.mhi) begin
      ph_r <= 64'(a_mag_r[63:32]) * 64'(b_mag_r);
    end
    if (cmd.mrnd) begin
      rmag_r <= (|rshift[95:62]) ? '1 : rshift[61:0];
    end
    if (cmd.mstore) begin
      case (cmd.op)
        OP_DV: m_dv_r <= mres;
        OP_VC: m_vc_r <= mres;
        OP_DU: m_du_r <= mres;
        OP_DWR: m_dwr_r <= mres;
        OP_DWZ: begin
          if (mres > DWZ_LIM) begin
            dwz_r <= DWZ_LIM;
          end else if (mres < -DWZ_LIM) begin
            dwz_r <= -DWZ_LIM;
          end else begin
            dwz_r <= mres;
          end
        end
        default: m_st_r <= mres;
      endcase
    end
    if (cmd.vz) begin
      vz_r <= sat32(m_dv_r + m_vc_r);
    end
  end

  logic               out_valid_r;
  logic [15:0]        out_radial_index_r;
  logic [7:0]         out_vertical_index_r;
  logic signed [31:0] out_vth_r, out_vz_r, out_st_r;

  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load && status.out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load && status.out_free) begin
      out_radial_index_r <= row_out_r;
      out_vertical_index_r <= 8'(k_r);
      out_vth_r <= sat32(m_du_r - m_dwr_r);
      out_vz_r <= vz_r;
      out_st_r <= sat32(m_st_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_radial_index = out_radial_index_r;
  assign out_vertical_index = out_vertical_index_r;
  assign out_vorticity_azimuthal = out_vth_r;
  assign out_vorticity_vertical = out_vz_r;
  assign out_stretching = out_st_r;

`ifndef SYNTHESIS
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result appeared without a load command");

  a_slots_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && status.interior) |=>
      (slot_c_r != slot_x_r && slot_p_r != slot_x_r && slot_c_r != slot_p_r))
    else $error("line buffer slots overlap");
`endif

endmodule

FILE: hdl/axisymmetric_vorticity_stencil_unit.sv
`timescale 1ns / 1ps
// Streams a radial-vertical grid plane, one cell per input transfer, radial row
// outer and vertical level inner, and returns vorticity results for interior cells.
// The input channel carries the velocities of one cell and its row's inverse
// radius; plane_start marks the first cell of a plane. Cells are counted against
// the configured row and level counts, and the counters wrap at the end of a plane.
// The result channel carries one transfer per interior cell: its indices, the
// azimuthal and vertical vorticity and the stretching term, all saturated Q16.16.
// Boundary cells are stored and produce no result, and the block stays ready for
// the next cell. An interior cell stalls the input while the block reads the line
// buffers on one read port per buffer, forms six products, each built from two 32
// by 32 partial products and rounded, and combines them into the results. The
// result sits in an output register, so the next cell is taken while it waits; a
// stalled receiver holds the block only once a second result is ready.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while idle, which the block itself does not enforce. A synchronous
// reset clears the counters and the handshake state and restores the default sizes
// and steps; line buffer contents are not cleared.
module axisymmetric_vorticity_stencil_unit
  import avs_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_radial_velocity,
  input  logic signed [31:0] in_azimuthal_velocity,
  input  logic signed [31:0] in_vertical_velocity,
  input  logic [31:0]        in_inverse_radius,
  input  logic               in_plane_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_radial_index,
  output logic [7:0]         out_vertical_index,
  output logic signed [31:0] out_vorticity_azimuthal,
  output logic signed [31:0] out_vorticity_vertical,
  output logic signed [31:0] out_stretching
);

  avs_cmd_t    cmd;
  avs_status_t status;

  avs_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status(status),
    .cmd(cmd)
  );

  avs_datapath #(.MAX_LEVELS(MAX_LEVELS)) u_datapath (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_radial_velocity(in_radial_velocity),
    .in_azimuthal_velocity(in_azimuthal_velocity),
    .in_vertical_velocity(in_vertical_velocity),
    .in_inverse_radius(in_inverse_radius),
    .in_plane_start(in_plane_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_radial_index(out_radial_index),
    .out_vertical_index(out_vertical_index),
    .out_vorticity_azimuthal(out_vorticity_azimuthal),
    .out_vorticity_vertical(out_vorticity_vertical),
    .out_stretching(out_stretching),
    .cmd(cmd),
    .status(status)
  );

endmodule

FILE: test/vorticity_checker.sv
`timescale 1ns / 1ps

module vorticity_checker
  import avs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_radial_velocity,
  input  logic signed [31:0] in_azimuthal_velocity,
  input  logic signed [31:0] in_vertical_velocity,
  input  logic [31:0]        in_inverse_radius,
  input  logic               in_plane_start,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_radial_index,
  input  logic [7:0]         out_vertical_index,
  input  logic signed [31:0] out_vorticity_azimuthal,
  input  logic signed [31:0] out_vorticity_vertical,
  input  logic signed [31:0] out_stretching,
  output int                 errors,
  output int                 pending
);

  localparam int LEVELS = 256;
  localparam int F = FRAC_BITS;

  typedef struct {
    logic [15:0]        ridx;
    logic [7:0]         kidx;
    logic signed [31:0] vth;
    logic signed [31:0] vz;
    logic signed [31:0] st;
  } vorticity_t;

  vorticity_t   vorticity_due[$];
  logic [31:0]  radial_cells, vertical_cells, inv_dr2, inv_dz2;
  logic [31:0]  u_rows [0:3*LEVELS-1];
  logic [31:0]  v_rows [0:3*LEVELS-1];
  logic [31:0]  w_rows [0:3*LEVELS-1];
  logic [31:0]  inv_r_rows [0:2];
  int           row_at, level_at;
  int           err_count;

  assign errors = err_count;

  function automatic longint scale_round(input longint a, input longint b, input int s);
    logic [127:0] ma, mb, p;
    logic         neg;
    longint       r;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    p = (ma * mb + (128'd1 << (s - 1))) >> s;
    if (p > 128'h3fff_ffff_ffff_ffff) begin
      p = 128'h3fff_ffff_ffff_ffff;
    end
    r = longint'(p[63:0]);
    return neg ? -r : r;
  endfunction

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic longint sv(input logic [31:0] x);
    longint r;
    r = $signed(x);
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic take_cell();
    int         nr, nz, row, lvl, x, c, p, k;
    longint     du, dwr, dv, wa, wb, dwz, lim, vth, vz;
    vorticity_t e;
    nr = (radial_cells < 3) ? 3 : radial_cells;
    nz = (vertical_cells < 3) ? 3 : ((vertical_cells > LEVELS) ? LEVELS : vertical_cells);
    row = row_at;
    lvl = level_at;
    if (in_plane_start) begin
      row = 0;
      lvl = 0;
    end
    if (lvl >= nz) begin
      lvl = 0;
      row++;
    end
    if (row >= nr) row = 0;
    x = row % 3;
    u_rows[x*LEVELS+lvl] = in_radial_velocity;
    v_rows[x*LEVELS+lvl] = in_azimuthal_velocity;
    w_rows[x*LEVELS+lvl] = in_vertical_velocity;
    inv_r_rows[x] = in_inverse_radius;
    if (row >= 2 && lvl >= 1 && lvl + 2 <= nz) begin
      c = (row + 2) % 3;
      p = (row + 1) % 3;
      k = lvl;
      du = sv(u_rows[c*LEVELS+k+1]) + sv(u_rows[p*LEVELS+k+1])
         - sv(u_rows[c*LEVELS+k-1]) - sv(u_rows[p*LEVELS+k-1]);
      dwr = sv(w_rows[x*LEVELS+k]) + sv(w_rows[x*LEVELS+k-1])
          - sv(w_rows[p*LEVELS+k]) - sv(w_rows[p*LEVELS+k-1]);
      dv = sv(v_rows[x*LEVELS+k]) - sv(v_rows[p*LEVELS+k]);
      wa = sv(w_rows[c*LEVELS+k+1]) + sv(w_rows[c*LEVELS+k]);
      wb = (k > 1) ? sv(w_rows[c*LEVELS+k-1]) + sv(w_rows[c*LEVELS+k-2])
                   : sv(w_rows[c*LEVELS]);
      lim = longint'(1) << (32 + F);
      vth = clip32(scale_round(du, longint'(inv_dz2), F + 1)
                 - scale_round(dwr, longint'(inv_dr2), F + 1));
      vz = clip32(scale_round(dv, longint'(inv_dr2), F)
                + scale_round(sv(v_rows[c*LEVELS+k]), longint'(inv_r_rows[c]), F));
      dwz = scale_round(wa - wb, longint'(inv_dz2), F + 1);
      if (dwz > lim) dwz = lim;
      if (dwz < -lim) dwz = -lim;
      e.ridx = 16'(row - 1);
      e.kidx = 8'(k);
      e.vth = vth[31:0];
      e.vz = vz[31:0];
      e.st = clip32(scale_round(dwz, vz, F));
      vorticity_due.push_back(e);
    end
    lvl++;
    if (lvl >= nz) begin
      lvl = 0;
      row++;
      if (row >= nr) row = 0;
    end
    row_at = row;
    level_at = lvl;
  endtask

  task automatic check_result();
    vorticity_t e;
    if (vorticity_due.size() == 0) begin
      report("unexpected result", out_radial_index, -1);
    end else begin
      e = vorticity_due.pop_front();
      if (out_radial_index !== e.ridx) report("radial_index", out_radial_index, e.ridx);
      if (out_vertical_index !== e.kidx) report("vertical_index", out_vertical_index, e.kidx);
      if (out_vorticity_azimuthal !== e.vth)
        report("vorticity_azimuthal", out_vorticity_azimuthal, e.vth);
      if (out_vorticity_vertical !== e.vz)
        report("vorticity_vertical", out_vorticity_vertical, e.vz);
      if (out_stretching !== e.st) report("stretching", out_stretching, e.st);
    end
  endtask

  initial err_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      radial_cells <= 32'(RADIAL_CELLS_RST);
      vertical_cells <= 32'(VERTICAL_CELLS_RST);
      inv_dr2 <= INV_STEP_RST;
      inv_dz2 <= INV_STEP_RST;
      row_at = 0;
      level_at = 0;
      vorticity_due.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_cell();
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIAL_CELLS:          radial_cells <= 32'(cfg_data[15:0]);
          CFG_VERTICAL_CELLS:        vertical_cells <= 32'(cfg_data[8:0]);
          CFG_INV_TWO_RADIAL_STEP:   inv_dr2 <= cfg_data;
          CFG_INV_TWO_VERTICAL_STEP: inv_dz2 <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= vorticity_due.size();
  end

endmodule

FILE: test/axisymmetric_vorticity_stencil_unit_tb.sv
`timescale 1ns / 1ps

module axisymmetric_vorticity_stencil_unit_tb;
  import avs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PLANNED_CELLS = 550;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_RADIAL_CELLS;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_radial_velocity = '0;
  logic signed [31:0] in_azimuthal_velocity = '0;
  logic signed [31:0] in_vertical_velocity = '0;
  logic [31:0]        in_inverse_radius = '0;
  logic               in_plane_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_radial_index;
  logic [7:0]         out_vertical_index;
  logic signed [31:0] out_vorticity_azimuthal;
  logic signed [31:0] out_vorticity_vertical;
  logic signed [31:0] out_stretching;
  int                 errors, pending;
  int                 cells_sent = 0;
  int                 cycles = 0;
  int                 send_idle_pct = 16;
  int                 recv_stall_pct = 48;

  axisymmetric_vorticity_stencil_unit DUT (.*);

  vorticity_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return 32'($urandom_range(32'h3ffff)) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cell(input logic [31:0] ur, va, wz, ir, input logic ps);
    if (cells_sent < PLANNED_CELLS / 3) begin
      send_idle_pct = 16;
      recv_stall_pct = 48;
    end else if (cells_sent < 2 * PLANNED_CELLS / 3) begin
      send_idle_pct = 48;
      recv_stall_pct = 16;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_radial_velocity <= ur;
    in_azimuthal_velocity <= va;
    in_vertical_velocity <= wz;
    in_inverse_radius <= ir;
    in_plane_start <= ps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cells_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [31:0] rc, vc, dr, dz);
    write_reg(CFG_RADIAL_CELLS, rc);
    write_reg(CFG_VERTICAL_CELLS, vc);
    write_reg(CFG_INV_TWO_RADIAL_STEP, dr);
    write_reg(CFG_INV_TWO_VERTICAL_STEP, dz);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] corner [0:5];
    int          rc, vc, nr, nz, planes, cells, rows;
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000,
               32'hffff_0000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner values on a 4 by 5 plane, including the lowest interior level.
    set_grid(4, 5, 32'hffff_ffff, 32'h8000_0000);
    for (int i = 0; i < 20; i++) begin
      send_cell(corner[i % 6], corner[(i + 1) % 6], corner[(i + 3) % 6],
                corner[(i + 2) % 6], i == 0);
    end
    settle();

    // Level count past the buffer depth, then the level count is shrunk mid-plane.
    set_grid(3, 511, 32'h0000_8000, 32'h0);
    for (int i = 0; i < 300; i++) begin
      send_cell(pick_word(), pick_word(), pick_word(), pick_word(), i == 0);
    end
    settle();
    set_grid(3, 5, 32'h0000_8000, 32'h0001_0000);
    for (int i = 0; i < 5; i++) begin
      send_cell(pick_word(), pick_word(), pick_word(), pick_word(), 1'b0);
    end
    settle();

    while (cells_sent < PLANNED_CELLS - 20) begin
      case ($urandom_range(7))
        0: rc = $urandom_range(2);
        1: rc = 65535;
        default: rc = $urandom_range(3, 6);
      endcase
      vc = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
      set_grid(rc, vc, pick_word(), ($urandom_range(3) == 0) ? pick_word() : $urandom_range(32'h3ffff));
      nr = (rc < 3) ? 3 : ((rc > 6) ? $urandom_range(3, 5) : rc);
      nz = (vc < 3) ? 3 : vc;
      planes = $urandom_range(1, 3);
      for (int p = 0; p < planes; p++) begin
        rows = ($urandom_range(4) == 0) ? $urandom_range(1, nr) : nr;
        cells = rows * nz - (($urandom_range(4) == 0) ? $urandom_range(nz - 1) : 0);
        for (int i = 0; i < cells; i++) begin
          send_cell(pick_word(), pick_word(), pick_word(), pick_word(),
                    (p == 0 && i == 0) || (i == 0 && $urandom_range(1) == 1) ||
                    $urandom_range(99) < 2);
        end
        if (cells != nr * nz) break;
      end
      settle();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: axisymmetric_vorticity_stencil_unit.f
hdl/avs_pkg.sv
hdl/avs_ram.sv
hdl/avs_ctrl.sv
hdl/avs_datapath.sv
hdl/axisymmetric_vorticity_stencil_unit.sv
test/vorticity_checker.sv
test/axisymmetric_vorticity_stencil_unit_tb.sv
